/* hdl/apr_pkg.sv */
// shared types for the aging page replacement block
`timescale 1ns / 1ps

package apr_pkg;

   // per-cell update command issued when a request is resolved
   typedef struct packed {
      logic step;   // shift this frame's age
      logic touch;  // this frame is the one referenced
      logic load;   // write the new page into this frame
   } cell_cmd_type;

endpackage

/* hdl/aging_page_replacement_core.sv */
// top level of the aging page replacement block: control, fill count and the frame cell row
//
// Usage:
//   One request on the req_ channel carries a page number. The block looks it
//   up among NUM_FRAMES frames and answers with one response on the rsp_
//   channel: fault (miss) or hit, the frame that now holds the page, and the
//   page that was evicted, if any. Free frames are filled in index order; once
//   all are full the frame with the smallest age is replaced, lowest index on
//   ties. Every age then shifts right and the used frame gets its top bit set.
// Timing:
//   A request is taken only while the block is idle. Its lookup travels as a
//   wave through the row of frame cells, one cell per cycle; the response is
//   registered once the wave has left the last cell, and no new request is
//   taken until the block has written that response and returned to idle.
// Reset and stalls:
//   Reset empties all frames and clears all ages. The response sits in an
//   output register; the next request can be accepted while it waits, and
//   that request is held before its update until the response is taken.
`timescale 1ns / 1ps

module aging_page_replacement_core
   import apr_pkg::*;
#(
   parameter int NUM_FRAMES = 8,
   parameter int PAGE_BITS  = 16,
   parameter int AGE_BITS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_page_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fault,
   output logic [2:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page
);

   localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int FILL_W = $clog2(NUM_FRAMES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_fault_ff, rsp_fault_in;
   logic [2:0]  rsp_frame_index_ff, rsp_frame_index_in;
   logic        rsp_evicted_valid_ff, rsp_evicted_valid_in;
   logic [15:0] rsp_evicted_page_ff, rsp_evicted_page_in;

   // scan carry between cells, slot i feeds cell i
   logic [NUM_FRAMES:0]  c_hit;
   logic [IDX_W-1:0]     c_hit_idx  [NUM_FRAMES+1];
   logic [NUM_FRAMES:0]  c_have;
   logic [AGE_BITS-1:0]  c_min_age  [NUM_FRAMES+1];
   logic [IDX_W-1:0]     c_min_idx  [NUM_FRAMES+1];
   logic [PAGE_BITS-1:0] c_min_page [NUM_FRAMES+1];

   cell_cmd_type cmd [NUM_FRAMES];

   logic                 req_fire;
   logic                 apply_fire;
   logic                 hit;
   logic                 full;
   logic                 evict;
   logic [IDX_W-1:0]     used;
   logic [PAGE_BITS+15:0] page_ext;
   logic [IDX_W+2:0]     used_ext;
   logic [PAGE_BITS+15:0] evict_ext;

   assign req_fire   = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // incoming page trimmed or widened to the frame tag width
   assign page_ext = {{PAGE_BITS{1'b0}}, req_page_number};
   assign page_in  = req_fire ? page_ext[PAGE_BITS-1:0] : page_ff;

   // leftmost cell starts with an empty carry
   assign c_hit[0]      = 1'b0;
   assign c_hit_idx[0]  = '0;
   assign c_have[0]     = 1'b0;
   assign c_min_age[0]  = '0;
   assign c_min_idx[0]  = '0;
   assign c_min_page[0] = '0;

   // resolve the request from the carry leaving the last cell
   always_comb begin
      hit   = c_hit[NUM_FRAMES];
      full  = (fill_ff == FILL_W'(NUM_FRAMES));
      evict = !hit && full && c_have[NUM_FRAMES];
      if (hit) begin
         used = c_hit_idx[NUM_FRAMES];
      end else if (full) begin
         used = c_min_idx[NUM_FRAMES];
      end else begin
         used = IDX_W'(fill_ff);
      end
      used_ext  = {3'b000, used};
      evict_ext = {16'h0000, c_min_page[NUM_FRAMES]};
   end

   // per-cell commands
   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      always_comb begin
         cmd[i].step  = apply_fire;
         cmd[i].touch = apply_fire && (used == IDX_W'(i));
         cmd[i].load  = apply_fire && (used == IDX_W'(i)) && !hit;
      end

      apr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .AGE_BITS  (AGE_BITS),
         .IDX_W     (IDX_W),
         .CELL_IDX  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd[i]),
         .req_page      (page_ff),
         .occupied      (FILL_W'(i) < fill_ff),
         .cin_hit       (c_hit[i]),
         .cin_hit_idx   (c_hit_idx[i]),
         .cin_have      (c_have[i]),
         .cin_min_age   (c_min_age[i]),
         .cin_min_idx   (c_min_idx[i]),
         .cin_min_page  (c_min_page[i]),
         .cout_hit      (c_hit[i+1]),
         .cout_hit_idx  (c_hit_idx[i+1]),
         .cout_have     (c_have[i+1]),
         .cout_min_age  (c_min_age[i+1]),
         .cout_min_idx  (c_min_idx[i+1]),
         .cout_min_page (c_min_page[i+1])
      );
   end

   // control sequence: idle, scan wave through the row, apply
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_W'(NUM_FRAMES - 1)) begin
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fill count grows on a miss while free frames remain
   assign fill_in = (apply_fire && !hit && !full) ? fill_ff + 1'b1 : fill_ff;

   // response register
   always_comb begin
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_fault_in         = rsp_fault_ff;
      rsp_frame_index_in   = rsp_frame_index_ff;
      rsp_evicted_valid_in = rsp_evicted_valid_ff;
      rsp_evicted_page_in  = rsp_evicted_page_ff;
      if (apply_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_fault_in         = !hit;
         rsp_frame_index_in   = used_ext[2:0];
         rsp_evicted_valid_in = evict;
         rsp_evicted_page_in  = evict ? evict_ext[15:0] : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff              <= page_in;
      rsp_fault_ff         <= rsp_fault_in;
      rsp_frame_index_ff   <= rsp_frame_index_in;
      rsp_evicted_valid_ff <= rsp_evicted_valid_in;
      rsp_evicted_page_ff  <= rsp_evicted_page_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;

endmodule

/* hdl/apr_cell.sv */
// one frame cell: page and age storage plus one stage of the lookup and victim scan
`timescale 1ns / 1ps

module apr_cell
   import apr_pkg::*;
#(
   parameter int PAGE_BITS = 16,
   parameter int AGE_BITS  = 8,
   parameter int IDX_W     = 3,
   parameter int CELL_IDX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [PAGE_BITS-1:0] req_page,
   input  logic                 occupied,
   // scan carry from the left neighbor
   input  logic                 cin_hit,
   input  logic [IDX_W-1:0]     cin_hit_idx,
   input  logic                 cin_have,
   input  logic [AGE_BITS-1:0]  cin_min_age,
   input  logic [IDX_W-1:0]     cin_min_idx,
   input  logic [PAGE_BITS-1:0] cin_min_page,
   // registered scan carry to the right neighbor
   output logic                 cout_hit,
   output logic [IDX_W-1:0]     cout_hit_idx,
   output logic                 cout_have,
   output logic [AGE_BITS-1:0]  cout_min_age,
   output logic [IDX_W-1:0]     cout_min_idx,
   output logic [PAGE_BITS-1:0] cout_min_page
);

   localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(CELL_IDX);
   localparam logic [AGE_BITS-1:0] AGE_TOP = AGE_BITS'(1) << (AGE_BITS - 1);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [AGE_BITS-1:0]  age_ff, age_in;

   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 have_ff, have_in;
   logic [AGE_BITS-1:0]  min_age_ff, min_age_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [PAGE_BITS-1:0] min_page_ff, min_page_in;

   logic match;
   logic take_min;

   // lookup and minimum stage, lowest index wins on both
   always_comb begin
      match       = occupied && (page_ff == req_page);
      take_min    = !cin_have || (age_ff < cin_min_age);
      hit_in      = cin_hit || match;
      hit_idx_in  = (!cin_hit && match) ? MY_IDX : cin_hit_idx;
      have_in     = 1'b1;
      min_age_in  = take_min ? age_ff  : cin_min_age;
      min_idx_in  = take_min ? MY_IDX  : cin_min_idx;
      min_page_in = take_min ? page_ff : cin_min_page;
   end

   // frame update: evicted or filled frame restarts at the top bit
   always_comb begin
      age_in  = age_ff;
      page_in = page_ff;
      if (cmd.step) begin
         if (cmd.load) begin
            age_in  = AGE_TOP;
            page_in = req_page;
         end else begin
            age_in = (age_ff >> 1) | (cmd.touch ? AGE_TOP : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else begin
         age_ff <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      have_ff     <= have_in;
      min_age_ff  <= min_age_in;
      min_idx_ff  <= min_idx_in;
      min_page_ff <= min_page_in;
   end

   assign cout_hit      = hit_ff;
   assign cout_hit_idx  = hit_idx_ff;
   assign cout_have     = have_ff;
   assign cout_min_age  = min_age_ff;
   assign cout_min_idx  = min_idx_ff;
   assign cout_min_page = min_page_ff;

endmodule

/* hdl/apr_checker.sv */
// port-level checks for the aging page replacement block, bound to the top level
`timescale 1ns / 1ps

module apr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_page_number,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fault,
   input logic [2:0]  rsp_frame_index,
   input logic        rsp_evicted_valid,
   input logic [15:0] rsp_evicted_page
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault)
         && $stable(rsp_frame_index) && $stable(rsp_evicted_valid)
         && $stable(rsp_evicted_page))
      else $error("response changed while stalled");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   // evicted page reads zero when nothing was evicted
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == 16'h0000)
      else $error("evicted page nonzero without eviction");

   // the block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // no response appears in the cycle right after a request is taken from idle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

endmodule

bind aging_page_replacement_core apr_checker u_apr_checker (.*);
